// ===== src/sct_pkg.sv =====
package sct_pkg;

  // fixed-point format of angle, terms and result
  localparam int FRAC_BITS = 28;
  localparam int ANGLE_W   = 32;

  // configuration register widths and reset values
  localparam int THR_W = 20;
  localparam int CAP_W = 6;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(24);

  // register map, index taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_TERM_CAP  = 1'b1;

  // term count
  localparam int MAX_TERMS = 32;
  localparam int TERM_W    = $clog2(MAX_TERMS);

  // term magnitude saturates at 2^61, running sum at plus or minus 2^61
  localparam int MAG_W = 62;
  localparam int ACC_W = MAG_W + 1;
  localparam logic [MAG_W-1:0] TERM_MAX = {1'b1, {(MAG_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] ONE_Q    = MAG_W'(1) << FRAC_BITS;

  // x*x is below 2^63, so the rounded square needs 2*ANGLE_W-1-FRAC_BITS bits
  localparam int X2_W    = 2 * ANGLE_W - 1 - FRAC_BITS;
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = (X2_W > ANGLE_W) ? X2_W : ANGLE_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int MAG_HI_W = MAG_W - MUL_A_W;
  localparam int SUM_W   = PROD_W + MUL_A_W + 1;
  localparam logic [SUM_W-1:0] RND_SUM = SUM_W'(1) << (FRAC_BITS - 1);

  // largest denominator is 62*63 = 3906
  localparam int D_W = 12;

  // divider retires DIV_BITS quotient bits per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_CYC   = (MAG_W + DIV_BITS - 1) / DIV_BITS;
  localparam int NUM_W     = DIV_CYC * DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_X2,
    ST_ACC,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_SUM,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MUL_SQUARE,
    MUL_LO,
    MUL_HI
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    mul_sel_e mul_sel;
    logic     x2_load;
    logic     acc_add;
    logic     n_inc;
    logic     d_load;
    logic     lo_save;
    logic     p_calc;
    logic     div_start;
    logic     term_update;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic below_thr;
    logic last_term;
    logic div_done;
  } dp_status_t;

  // series denominator for term n: (2n)(2n+1) for sine, (2n-1)(2n) for cosine
  function automatic logic [D_W-1:0] denom(input logic cosine, input logic [TERM_W-1:0] n);
    logic [TERM_W+1:0] two_n;
    logic [TERM_W+1:0] other;
    logic [2*TERM_W+3:0] prod;
    two_n = {1'b0, n, 1'b0};
    other = cosine ? two_n - (TERM_W+2)'(1) : two_n + (TERM_W+2)'(1);
    prod  = two_n * other;
    return prod[D_W-1:0];
  endfunction

endpackage

// ===== src/sct_div.sv =====
module sct_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sct_pkg::NUM_W-1:0]    num_i,
  input  logic [sct_pkg::D_W-1:0]      den_i,
  output logic                         done_o,
  output logic [sct_pkg::NUM_W-1:0]    quot_o
);

  logic                            run_q;
  logic [sct_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [sct_pkg::NUM_W-1:0]       quo_q, quo_d;
  logic [sct_pkg::D_W-1:0]         rem_q, rem_d;
  logic [sct_pkg::D_W-1:0]         den_q;

  // restoring division, DIV_BITS bits per cycle
  always_comb begin
    logic [sct_pkg::D_W:0] trial;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < sct_pkg::DIV_BITS; i++) begin
      trial = {rem_d, quo_d[sct_pkg::NUM_W-1]};
      quo_d = {quo_d[sct_pkg::NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[sct_pkg::D_W-1:0];
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= sct_pkg::DIV_CNT_W'(sct_pkg::DIV_CYC - 1);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - sct_pkg::DIV_CNT_W'(1);
      end
    end
  end

  // numerator shifts out as quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (run_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = !run_q;
  assign quot_o = quo_q;

endmodule

// ===== src/sct_dp.sv =====
module sct_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sct_pkg::dp_cmd_t                   cmd_i,
  output sct_pkg::dp_status_t                status_o,
  input  logic                               kind_i,
  input  logic signed [sct_pkg::ANGLE_W-1:0] angle_i,
  input  logic [sct_pkg::THR_W-1:0]          thr_i,
  input  logic [sct_pkg::CAP_W-1:0]          cap_i,
  output logic signed [sct_pkg::ANGLE_W-1:0] value_o,
  output logic                               capped_o,
  output logic                               valid_o
);

  logic                              cos_q;
  logic                              xneg_q;
  logic [sct_pkg::ANGLE_W-1:0]       ax_q;
  logic [sct_pkg::X2_W-1:0]          x2_q;
  logic [sct_pkg::MAG_W-1:0]         mag_q;
  logic                              neg_q;
  logic signed [sct_pkg::ACC_W-1:0]  acc_q;
  logic                              capped_q;
  logic [sct_pkg::TERM_W-1:0]        n_q;
  logic [sct_pkg::D_W-1:0]           d_q;
  logic [sct_pkg::PROD_W-1:0]        prod_q;
  logic [sct_pkg::PROD_W-1:0]        lo_q;
  logic [sct_pkg::MAG_W-1:0]         p_q;
  logic signed [sct_pkg::ANGLE_W-1:0] value_q;
  logic                              capped_out_q;
  logic                              valid_q;

  logic [sct_pkg::ANGLE_W-1:0]       ax_d;
  logic [sct_pkg::MUL_A_W-1:0]       mul_a;
  logic [sct_pkg::MUL_B_W-1:0]       mul_b;
  logic [sct_pkg::PROD_W:0]          sq_rnd;
  logic [sct_pkg::SUM_W-1:0]         psum;
  logic [sct_pkg::SUM_W-sct_pkg::FRAC_BITS-1:0] pshift;
  logic [sct_pkg::MAG_W-1:0]         p_d;
  logic signed [sct_pkg::ACC_W:0]    acc_sum;
  logic signed [sct_pkg::ACC_W-1:0]  acc_d;
  logic [sct_pkg::CAP_W-1:0]         cap_eff;
  logic [sct_pkg::CAP_W-1:0]         cap_last;
  logic [sct_pkg::NUM_W-1:0]         div_num;
  logic [sct_pkg::NUM_W-1:0]         div_quot;
  logic                              div_done;
  logic signed [sct_pkg::ANGLE_W-1:0] value_d;

  localparam int FRAC_BITS_C = sct_pkg::FRAC_BITS;
  localparam logic signed [sct_pkg::ACC_W:0] SUM_HI = (sct_pkg::ACC_W+1)'(sct_pkg::TERM_MAX);
  localparam logic signed [sct_pkg::ACC_W:0] SUM_LO = -SUM_HI;
  localparam logic signed [sct_pkg::ACC_W-1:0] OUT_HI =
    sct_pkg::ACC_W'({1'b0, {(sct_pkg::ANGLE_W-1){1'b1}}});
  localparam logic signed [sct_pkg::ACC_W-1:0] OUT_LO = -OUT_HI - sct_pkg::ACC_W'(1);

  // magnitude of the angle; the most negative code gives 2^31
  assign ax_d = angle_i[sct_pkg::ANGLE_W-1] ? (~angle_i + sct_pkg::ANGLE_W'(1)) : angle_i;

  // shared multiplier operand select
  always_comb begin
    unique case (cmd_i.mul_sel)
      sct_pkg::MUL_SQUARE: begin
        mul_a = ax_q;
        mul_b = sct_pkg::MUL_B_W'(ax_q);
      end
      sct_pkg::MUL_LO: begin
        mul_a = mag_q[sct_pkg::MUL_A_W-1:0];
        mul_b = sct_pkg::MUL_B_W'(x2_q);
      end
      sct_pkg::MUL_HI: begin
        mul_a = sct_pkg::MUL_A_W'(mag_q[sct_pkg::MAG_W-1:sct_pkg::MUL_A_W]);
        mul_b = sct_pkg::MUL_B_W'(x2_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // rounded square of the angle
  assign sq_rnd = {1'b0, prod_q} + (sct_pkg::PROD_W+1)'(sct_pkg::RND_SUM);

  // recombine partial products, round, drop fraction bits, saturate
  assign psum   = sct_pkg::SUM_W'(lo_q) + (sct_pkg::SUM_W'(prod_q) << sct_pkg::MUL_A_W)
                  + sct_pkg::RND_SUM;
  assign pshift = psum[sct_pkg::SUM_W-1:FRAC_BITS_C];
  assign p_d    = (pshift > (sct_pkg::SUM_W-FRAC_BITS_C)'(sct_pkg::TERM_MAX)) ?
                  sct_pkg::TERM_MAX : pshift[sct_pkg::MAG_W-1:0];

  // signed accumulate with saturation to plus or minus 2^61
  always_comb begin
    if (neg_q) begin
      acc_sum = (sct_pkg::ACC_W+1)'(acc_q) - (sct_pkg::ACC_W+1)'(mag_q);
    end else begin
      acc_sum = (sct_pkg::ACC_W+1)'(acc_q) + (sct_pkg::ACC_W+1)'(mag_q);
    end
    if (acc_sum > SUM_HI) begin
      acc_d = sct_pkg::ACC_W'(SUM_HI);
    end else if (acc_sum < SUM_LO) begin
      acc_d = sct_pkg::ACC_W'(SUM_LO);
    end else begin
      acc_d = acc_sum[sct_pkg::ACC_W-1:0];
    end
  end

  // term cap clamped to 1..32
  always_comb begin
    if (cap_i == '0) begin
      cap_eff = sct_pkg::CAP_W'(1);
    end else if (cap_i > sct_pkg::CAP_W'(sct_pkg::MAX_TERMS)) begin
      cap_eff = sct_pkg::CAP_W'(sct_pkg::MAX_TERMS);
    end else begin
      cap_eff = cap_i;
    end
    cap_last = cap_eff - sct_pkg::CAP_W'(1);
  end

  assign status_o.below_thr = mag_q < sct_pkg::MAG_W'(thr_i);
  assign status_o.last_term = n_q == cap_last[sct_pkg::TERM_W-1:0];
  assign status_o.div_done  = div_done;

  // rounded division by the term denominator
  assign div_num = sct_pkg::NUM_W'(p_q) + sct_pkg::NUM_W'(d_q >> 1);

  sct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (d_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // saturate the sum to the output range
  always_comb begin
    if (acc_q > OUT_HI) begin
      value_d = {1'b0, {(sct_pkg::ANGLE_W-1){1'b1}}};
    end else if (acc_q < OUT_LO) begin
      value_d = {1'b1, {(sct_pkg::ANGLE_W-1){1'b0}}};
    end else begin
      value_d = acc_q[sct_pkg::ANGLE_W-1:0];
    end
  end

  // series state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cos_q  <= kind_i;
      xneg_q <= angle_i[sct_pkg::ANGLE_W-1];
      ax_q   <= ax_d;
    end
    if (cmd_i.x2_load) begin
      x2_q  <= sq_rnd[FRAC_BITS_C+sct_pkg::X2_W-1:FRAC_BITS_C];
      mag_q <= cos_q ? sct_pkg::ONE_Q : sct_pkg::MAG_W'(ax_q);
      neg_q <= cos_q ? 1'b0 : xneg_q;
      acc_q <= '0;
      n_q   <= '0;
    end
    if (cmd_i.acc_add) begin
      acc_q    <= acc_d;
      capped_q <= !status_o.below_thr;
    end
    if (cmd_i.n_inc) begin
      n_q <= n_q + sct_pkg::TERM_W'(1);
    end
    if (cmd_i.d_load) begin
      d_q <= sct_pkg::denom(cos_q, n_q);
    end
    if (cmd_i.lo_save) begin
      lo_q <= prod_q;
    end
    if (cmd_i.p_calc) begin
      p_q <= p_d;
    end
    if (cmd_i.term_update) begin
      mag_q <= div_quot[sct_pkg::MAG_W-1:0];
      neg_q <= !neg_q;
    end
    if (cmd_i.out_load) begin
      value_q      <= value_d;
      capped_out_q <= capped_q;
    end
  end

  // one-cycle result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.out_load;
    end
  end

  assign value_o  = value_q;
  assign capped_o = capped_out_q;
  assign valid_o  = valid_q;

endmodule

// ===== src/sct_ctrl.sv =====
module sct_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sct_pkg::dp_status_t  status_i,
  output sct_pkg::dp_cmd_t     cmd_o,
  output logic                 busy_o
);

  sct_pkg::ctrl_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sct_pkg::ST_IDLE: begin
        if (start_i) state_d = sct_pkg::ST_SQUARE;
      end
      sct_pkg::ST_SQUARE:   state_d = sct_pkg::ST_X2;
      sct_pkg::ST_X2:       state_d = sct_pkg::ST_ACC;
      sct_pkg::ST_ACC: begin
        if (status_i.below_thr || status_i.last_term) begin
          state_d = sct_pkg::ST_DONE;
        end else begin
          state_d = sct_pkg::ST_MUL_LO;
        end
      end
      sct_pkg::ST_MUL_LO:   state_d = sct_pkg::ST_MUL_HI;
      sct_pkg::ST_MUL_HI:   state_d = sct_pkg::ST_MUL_SUM;
      sct_pkg::ST_MUL_SUM:  state_d = sct_pkg::ST_DIV_LOAD;
      sct_pkg::ST_DIV_LOAD: state_d = sct_pkg::ST_DIV;
      sct_pkg::ST_DIV: begin
        if (status_i.div_done) state_d = sct_pkg::ST_ACC;
      end
      sct_pkg::ST_DONE:     state_d = sct_pkg::ST_IDLE;
      default:              state_d = sct_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sct_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.mul_sel = sct_pkg::MUL_SQUARE;
    unique case (state_q)
      sct_pkg::ST_IDLE:     cmd_o.load = start_i;
      sct_pkg::ST_SQUARE:   cmd_o.mul_sel = sct_pkg::MUL_SQUARE;
      sct_pkg::ST_X2:       cmd_o.x2_load = 1'b1;
      sct_pkg::ST_ACC: begin
        cmd_o.acc_add = 1'b1;
        cmd_o.n_inc   = !(status_i.below_thr || status_i.last_term);
      end
      sct_pkg::ST_MUL_LO: begin
        cmd_o.mul_sel = sct_pkg::MUL_LO;
        cmd_o.d_load  = 1'b1;
      end
      sct_pkg::ST_MUL_HI: begin
        cmd_o.mul_sel = sct_pkg::MUL_HI;
        cmd_o.lo_save = 1'b1;
      end
      sct_pkg::ST_MUL_SUM:  cmd_o.p_calc = 1'b1;
      sct_pkg::ST_DIV_LOAD: cmd_o.div_start = 1'b1;
      sct_pkg::ST_DIV:      cmd_o.term_update = status_i.div_done;
      sct_pkg::ST_DONE:     cmd_o.out_load = 1'b1;
      default:              cmd_o.out_load = 1'b0;
    endcase
  end

  assign busy_o = state_q != sct_pkg::ST_IDLE;

endmodule

// ===== src/sine_cosine_taylor_series_core.sv =====
// Sine or cosine of a signed Q3.28 angle by Taylor series, summed one term at a
// time on a shared 32x35 multiplier and a 4-bit-per-cycle divider. An item is
// accepted when start is high and busy is low; busy then stays high until the
// result appears on value_o and capped_o with valid_o high for exactly one cycle,
// which the receiver cannot stall, so it must take the result in that cycle.
// The next item may start in the strobe cycle; each extra term of the series
// costs two multiplier passes, one recombine, one divider load, a divider run
// and an accumulate. The series ends at the first term below stop_threshold or
// at term_cap terms (0 counts as 1, above 32 as 32); capped_o is set when it
// stops at term_cap with the last term not below stop_threshold.
// Registers: stop_threshold at byte address 0, term_cap at byte address 4.
module sine_cosine_taylor_series_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind_i,
  input  logic signed [sct_pkg::ANGLE_W-1:0] angle_i,
  output logic signed [sct_pkg::ANGLE_W-1:0] value_o,
  output logic                               capped_o,
  output logic                               valid_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [sct_pkg::THR_W-1:0] thr_q;
  logic [sct_pkg::CAP_W-1:0] cap_q;
  logic                      cfg_wr;
  logic                      busy_w;
  sct_pkg::dp_cmd_t          cmd;
  sct_pkg::dp_status_t       status;

  // register write transaction
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= sct_pkg::THR_RESET;
      cap_q <= sct_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        sct_pkg::REG_THRESHOLD: thr_q <= pwdata[sct_pkg::THR_W-1:0];
        sct_pkg::REG_TERM_CAP:  cap_q <= pwdata[sct_pkg::CAP_W-1:0];
        default:                thr_q <= thr_q;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[2])
      sct_pkg::REG_THRESHOLD: prdata = 32'(thr_q);
      sct_pkg::REG_TERM_CAP:  prdata = 32'(cap_q);
      default:                prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  sct_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_w)
  );

  sct_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .kind_i   (kind_i),
    .angle_i  (angle_i),
    .thr_i    (thr_q),
    .cap_i    (cap_q),
    .value_o  (value_o),
    .capped_o (capped_o),
    .valid_o  (valid_o)
  );

  assign busy = busy_w;

endmodule

// ===== src/sct_checker.sv =====
module sct_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic valid_o
);

  // an accepted start makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after accepted start");

  // the result shows as the block goes idle
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while busy");

  // busy only ends with a result
  a_fell_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("busy dropped without a result");

  // the result strobe is a single pulse, never held high
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

endmodule

bind sine_cosine_taylor_series_core sct_checker u_sct_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  // function select codes and register addresses
  localparam logic KIND_SINE   = 1'b0;
  localparam logic KIND_COSINE = 1'b1;
  localparam logic [2:0] ADDR_THRESHOLD = {sct_pkg::REG_THRESHOLD, 2'b00};
  localparam logic [2:0] ADDR_TERM_CAP  = {sct_pkg::REG_TERM_CAP, 2'b00};

  // fixed-point constants of the series
  localparam int          FRAC      = sct_pkg::FRAC_BITS;
  localparam int unsigned TERM_MOST = 32;
  localparam logic [63:0] HALF_LSB  = 64'(1) << (FRAC - 1);
  localparam logic [63:0] ONE_RAW   = 64'(1) << FRAC;
  localparam logic [63:0] MAG_LIMIT = 64'(1) << 61;
  localparam logic signed [63:0] ACC_LIMIT = 64'sh2000_0000_0000_0000;

  // angles in Q3.28
  localparam logic [31:0] ANG_ZERO     = 32'h0000_0000;
  localparam logic [31:0] ANG_LSB      = 32'h0000_0001;
  localparam logic [31:0] ANG_NEG_LSB  = 32'hFFFF_FFFF;
  localparam logic [31:0] ANG_HALF     = 32'h0800_0000;
  localparam logic [31:0] ANG_ONE      = 32'h1000_0000;
  localparam logic [31:0] ANG_HALF_PI  = 32'h1921_FB54;
  localparam logic [31:0] ANG_PI       = 32'h3243_F6A9;
  localparam logic [31:0] ANG_NEG_PI   = 32'hCDBC_0957;
  localparam logic [31:0] ANG_FOUR     = 32'h4000_0000;
  localparam logic [31:0] ANG_NEG_FOUR = 32'hC000_0000;
  localparam logic [31:0] ANG_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] ANG_MIN      = 32'h8000_0000;

  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int DRAIN_CYCLES    = 50;
  localparam int CYCLE_LIMIT     = 1_500_000;

  typedef struct packed {
    logic [31:0] value;
    logic        capped;
  } sct_result_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_SET_THR,
    ROW_SET_CAP
  } row_act_e;

  typedef struct packed {
    row_act_e    act;
    logic        kind;
    logic [31:0] arg;
    logic        known;
    sct_result_t want;
  } dir_row_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;
  logic        start   = 1'b0;
  logic        kind_i  = 1'b0;
  logic [31:0] angle_i = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic [31:0] value_o;
  logic        capped_o;
  logic        valid_o;
  logic [31:0] prdata;
  logic        pready;

  // local copy of the configuration registers
  logic [sct_pkg::THR_W-1:0] model_thr = sct_pkg::THR_RESET;
  logic [sct_pkg::CAP_W-1:0] model_cap = sct_pkg::CAP_RESET;

  sct_result_t pending_results[$];
  sct_result_t oldest_result;
  dir_row_t    dir_rows[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;

  sine_cosine_taylor_series_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .kind_i  (kind_i),
    .angle_i (angle_i),
    .value_o (value_o),
    .capped_o(capped_o),
    .valid_o (valid_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // sum the series term by term with the current register settings
  function automatic sct_result_t series_value(input logic cosine, input logic [31:0] angle);
    logic               xneg;
    logic [31:0]        ax;
    logic [63:0]        x2;
    logic [63:0]        mag;
    logic [63:0]        p;
    logic [127:0]       prod;
    logic               neg;
    logic               done;
    logic signed [63:0] acc;
    int unsigned        cap;
    int unsigned        d;
    int unsigned        n;
    sct_result_t        res;
    xneg = angle[31];
    ax   = xneg ? (~angle + 32'd1) : angle;
    x2   = (64'(ax) * 64'(ax) + HALF_LSB) >> FRAC;
    cap  = (model_cap == 0) ? 1 : ((model_cap > TERM_MOST) ? TERM_MOST : model_cap);
    mag  = cosine ? ONE_RAW : 64'(ax);
    neg  = cosine ? 1'b0 : xneg;
    acc  = '0;
    res.capped = 1'b1;
    done = 1'b0;
    for (n = 0; n < cap && !done; n++) begin
      // next term from the previous one, rounded at each step
      if (n > 0) begin
        d    = cosine ? (2 * n - 1) * (2 * n) : (2 * n) * (2 * n + 1);
        prod = 128'(mag) * 128'(x2) + 128'(HALF_LSB);
        prod = prod >> FRAC;
        p    = (prod > 128'(MAG_LIMIT)) ? MAG_LIMIT : prod[63:0];
        mag  = (p + 64'(d / 2)) / 64'(d);
        neg  = ~neg;
      end
      acc = neg ? acc - $signed(mag) : acc + $signed(mag);
      if (acc > ACC_LIMIT) acc = ACC_LIMIT;
      if (acc < -ACC_LIMIT) acc = -ACC_LIMIT;
      if (mag < 64'(model_thr)) begin
        res.capped = 1'b0;
        done = 1'b1;
      end
    end
    // saturate the sum to the output range
    if (acc > 64'sd2147483647) begin
      res.value = 32'h7FFF_FFFF;
    end else if (acc < -64'sd2147483648) begin
      res.value = 32'h8000_0000;
    end else begin
      res.value = acc[31:0];
    end
    return res;
  endfunction

  // present one transaction and hold it until accepted
  task automatic send_item(input logic k, input logic [31:0] a, input logic known,
                           input sct_result_t want);
    start   <= 1'b1;
    kind_i  <= k;
    angle_i <= a;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (known) begin
      pending_results.push_back(want);
    end else begin
      pending_results.push_back(series_value(k, a));
    end
  endtask

  // register write, only once the block has drained
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    while (pending_results.size() != 0 || busy) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_THRESHOLD) begin
      model_thr = data[sct_pkg::THR_W-1:0];
    end else if (addr == ADDR_TERM_CAP) begin
      model_cap = data[sct_pkg::CAP_W-1:0];
    end
    // leave the bus idle before the next transaction
    @(posedge clk_i);
  endtask

  // compare each result strobe with the oldest pending transaction
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual value %h capped %b",
                 $time, value_o, capped_o);
        mismatch_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (value_o !== oldest_result.value) begin
          $display("%0t: value mismatch: expected %h, actual %h",
                   $time, oldest_result.value, value_o);
          mismatch_count++;
        end
        if (capped_o !== oldest_result.capped) begin
          $display("%0t: capped mismatch: expected %b, actual %b",
                   $time, oldest_result.capped, capped_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic        k;
    logic [31:0] angle;
    logic [31:0] thr;
    logic [31:0] cap;
    int          burst_left;

    // directed transactions, typed results only where obvious
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_ZERO,     1'b1, {32'h0000_0000, 1'b0}});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_ZERO,     1'b1, {ANG_ONE, 1'b0}});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_LSB,      1'b1, {32'h0000_0001, 1'b0}});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_NEG_LSB,  1'b1, {32'hFFFF_FFFF, 1'b0}});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_FOUR,     1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_NEG_FOUR, 1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_FOUR,     1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_NEG_FOUR, 1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_MAX,      1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_MAX,      1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_MIN,      1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_MIN,      1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_HALF_PI,  1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_PI,       1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_NEG_LSB,  1'b0, 33'd0});
    // zero threshold, every series runs to the cap
    dir_rows.push_back({ROW_SET_THR, 1'b0, 32'd0, 1'b0, 33'd0});
    dir_rows.push_back({ROW_SET_CAP, 1'b0, 32'd5, 1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_ONE,      1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_ZERO,     1'b1, {ANG_ONE, 1'b1}});
    // cap of zero counts as one term
    dir_rows.push_back({ROW_SET_CAP, 1'b0, 32'd0, 1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_HALF,     1'b1, {ANG_HALF, 1'b1}});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_NEG_FOUR, 1'b1, {ANG_ONE, 1'b1}});
    // largest threshold, cap above the term limit
    dir_rows.push_back({ROW_SET_THR, 1'b0, 32'd1048575, 1'b0, 33'd0});
    dir_rows.push_back({ROW_SET_CAP, 1'b0, 32'd63, 1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_ONE,      1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_NEG_PI,   1'b0, 33'd0});
    dir_rows.push_back({ROW_SET_THR, 1'b0, 32'd1, 1'b0, 33'd0});
    dir_rows.push_back({ROW_SET_CAP, 1'b0, 32'd32, 1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_MAX,      1'b0, 33'd0});
    // single term: threshold wins when the only term is small enough
    dir_rows.push_back({ROW_SET_CAP, 1'b0, 32'd1, 1'b0, 33'd0});
    dir_rows.push_back({ROW_ITEM, KIND_SINE,   ANG_ZERO,     1'b1, {32'h0000_0000, 1'b0}});
    dir_rows.push_back({ROW_ITEM, KIND_COSINE, ANG_FOUR,     1'b1, {ANG_ONE, 1'b1}});

    // reset
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir_rows[r]) begin
      case (dir_rows[r].act)
        ROW_ITEM: begin
          send_item(dir_rows[r].kind, dir_rows[r].arg, dir_rows[r].known, dir_rows[r].want);
        end
        ROW_SET_THR: begin
          start <= 1'b0;
          write_reg(ADDR_THRESHOLD, dir_rows[r].arg);
        end
        default: begin
          start <= 1'b0;
          write_reg(ADDR_TERM_CAP, dir_rows[r].arg);
        end
      endcase
    end
    start <= 1'b0;

    // random part, one register setting per phase
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          thr = 32'd1;
          cap = 32'd24;
        end
        1: begin
          thr = 32'd0;
          cap = 32'd32;
        end
        2: begin
          thr = 32'd1048575;
          cap = 32'd1;
        end
        3: begin
          thr = $urandom_range(0, 4095);
          cap = $urandom_range(1, 32);
        end
        default: begin
          thr = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 255)
                                            : $urandom_range(0, 1048575);
          cap = $urandom_range(0, 63);
        end
      endcase
      write_reg(ADDR_THRESHOLD, thr);
      write_reg(ADDR_TERM_CAP, cap);

      burst_left = $urandom_range(1, 24);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        k = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0:       angle = $urandom();
          1:       angle = $urandom_range(0, 32'h0001_FFFF) - 32'h0001_0000;
          default: angle = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
        endcase
        send_item(k, angle, 1'b0, 33'd0);
        burst_left--;
        if (burst_left == 0 || i == ITEMS_PER_PHASE - 1) begin
          start <= 1'b0;
          if (i != ITEMS_PER_PHASE - 1) begin
            // gap between bursts, sometimes timed from the end of busy
            @(posedge clk_i);
            case ($urandom_range(0, 2))
              0: ;
              1: begin
                while (busy) @(posedge clk_i);
                repeat ($urandom_range(0, 6)) @(posedge clk_i);
              end
              default: repeat ($urandom_range(1, 20)) @(posedge clk_i);
            endcase
            burst_left = $urandom_range(1, 24);
          end
        end
      end
    end

    // drain and look for stray results
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
